// ===== src/rhsl_pkg.sv =====
// shared constants and types for the rgb to hsl converter
`timescale 1ns / 1ps

package rhsl_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int CHAN_W            = 8;
  localparam int OUT_W             = 16;
  // divisor up to six times the channel range, remainder stays below it
  localparam int DEN_W             = 11;
  localparam int REM_W             = 11;
  localparam int NUM_LANES         = 2;

  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
  } lane_t;

endpackage

// ===== src/rgb_to_hsl_converter_top.sv =====
// rgb to hsl converter: front end and bit-per-stage division pipeline
`timescale 1ns / 1ps

// a request taken with start shows its result with done high after the front register,
//   one stage per quotient bit and the output register
// throughput: one pixel per clock, busy is never raised; the pipeline never stalls
// reset: rst (synchronous, active high) clears all valid bits and done; payload is not reset
module rgb_to_hsl_converter_top
  import rhsl_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  output logic              done,
  output logic [OUT_W-1:0]  hue,
  output logic [OUT_W-1:0]  saturation,
  output logic [OUT_W-1:0]  lightness
);

  localparam int F = FRACTION_BITS;

  // lightness scale 2^F-1 split as 510*LIG_Q + LIG_R, so only the small rest is divided
  localparam int LIG_Q     = ((1 << F) - 1) / 510;
  localparam int LIG_R     = ((1 << F) - 1) % 510;
  // reciprocal of 510, exact for every numerator below 2^18
  localparam int LIG_SHIFT = 27;
  localparam int LIG_M     = ((1 << LIG_SHIFT) + 509) / 510;

  // pipeline storage, index 0 is the front register, index F the last divide stage
  logic              vld  [0:F];
  logic              grey [0:F];
  lane_t             ln   [0:F][0:NUM_LANES-1];
  logic [F-1:0]      num  [0:F][0:NUM_LANES-1];
  logic [F-1:0]      quo  [0:F][0:NUM_LANES-1];

  // lightness path, aligned with the divide stages
  logic [17:0]       lig_tr;
  logic [F-1:0]      lig_tq0;
  logic [36:0]       lig_prod;
  logic [F-1:0]      lig_tq1;
  logic [F-1:0]      lig_val [2:F];

  // front end signals
  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;
  logic [CHAN_W:0]   sum;
  logic [CHAN_W-1:0] d;
  logic [11:0]       d12;
  logic [11:0]       d6;
  logic signed [11:0] n_raw;
  logic signed [11:0] n_wrap;
  logic [CHAN_W:0]   sat_den;
  logic              accept;

  // the receiver cannot stall and every stage moves each cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // largest and smallest channel
  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
  end

  assign sum = {1'b0, mx} + {1'b0, mn};
  assign d   = mx - mn;
  assign d12 = {4'b0, d};
  assign d6  = (d12 << 2) + (d12 << 1);

  // hue numerator in units of 1/(6d), first channel equal to max wins
  always_comb begin
    priority if (red == mx) begin
      n_raw = $signed({4'b0, green}) - $signed({4'b0, blue});
    end else if (green == mx) begin
      n_raw = $signed(d12 << 1) + $signed({4'b0, blue}) - $signed({4'b0, red});
    end else begin
      n_raw = $signed(d12 << 2) + $signed({4'b0, red}) - $signed({4'b0, green});
    end
    // a negative angle wraps by one full turn
    if (n_raw < 0) begin
      n_wrap = n_raw + $signed(d6);
    end else begin
      n_wrap = n_raw;
    end
  end

  // saturation divisor picks the side of one half lightness
  assign sat_den = (sum < 9'd255) ? sum : (9'd510 - sum);

  // front register: set up two lanes of long division and the lightness products
  // for a numerator x*(2^F-1) the upper part is x-1 and the lower F bits are -x
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
    grey[0] <= (d == '0);

    ln[0][LANE_HUE].rem <= REM_W'(n_wrap[10:0]);
    ln[0][LANE_HUE].den <= d6[DEN_W-1:0];
    num[0][LANE_HUE]    <= '0;

    ln[0][LANE_SAT].rem <= REM_W'(d - CHAN_W'(d != '0));
    ln[0][LANE_SAT].den <= DEN_W'(sat_den);
    num[0][LANE_SAT]    <= F'(0) - F'(d);

    lig_tr  <= 18'(sum * LIG_R);
    lig_tq0 <= F'(sum * LIG_Q);

    for (int l = 0; l < NUM_LANES; l++) begin
      quo[0][l] <= '0;
    end
  end

  // lightness: whole part plus the divided rest, then delayed to the last stage
  always_ff @(posedge clk) begin
    lig_prod   <= lig_tr * 37'(LIG_M);
    lig_tq1    <= lig_tq0;
    lig_val[2] <= lig_tq1 + F'(lig_prod[36:LIG_SHIFT]);
    for (int k = 2; k < F; k++) begin
      lig_val[k+1] <= lig_val[k];
    end
  end

  // one restoring division step per stage, one quotient bit each
  for (genvar k = 0; k < F; k++) begin : g_div
    logic [REM_W:0] trial [NUM_LANES];
    logic           fits  [NUM_LANES];

    always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
        trial[l] = {ln[k][l].rem, num[k][l][F-1]};
        fits[l]  = (trial[l] >= {1'b0, ln[k][l].den});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      grey[k+1] <= grey[k];
      for (int l = 0; l < NUM_LANES; l++) begin
        ln[k+1][l].den <= ln[k][l].den;
        if (fits[l]) begin
          ln[k+1][l].rem <= REM_W'(trial[l] - {1'b0, ln[k][l].den});
        end else begin
          ln[k+1][l].rem <= trial[l][REM_W-1:0];
        end
        num[k+1][l] <= num[k][l] << 1;
        quo[k+1][l] <= {quo[k][l][F-2:0], fits[l]};
      end
    end
  end

  // output register, grey pixels force hue and saturation to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[F];
    end
    hue        <= grey[F] ? '0 : OUT_W'(quo[F][LANE_HUE]);
    saturation <= grey[F] ? '0 : OUT_W'(quo[F][LANE_SAT]);
    lightness  <= OUT_W'(lig_val[F]);
  end

endmodule

// ===== src/rhsl_checker.sv =====
// port level checks for the rgb to hsl converter and their binding
`timescale 1ns / 1ps

module rhsl_checker
  import rhsl_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [CHAN_W-1:0] red,
  input logic [CHAN_W-1:0] green,
  input logic [CHAN_W-1:0] blue,
  input logic              done,
  input logic [OUT_W-1:0]  hue,
  input logic [OUT_W-1:0]  saturation,
  input logic [OUT_W-1:0]  lightness
);

  localparam int LAT = FRACTION_BITS + 2;

  // never holds requests off
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // every request gives its result after the fixed latency
  a_req_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing");

  // no result without a request
  a_done_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without request");

  // a grey pixel has no hue and no saturation
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (done && $past(red == green && green == blue, LAT)) |-> (hue == '0 && saturation == '0))
    else $error("grey pixel with colour");

  // any hue implies a coloured pixel
  a_hue_sat: assert property (@(posedge clk) disable iff (rst)
    (done && hue != '0) |-> (saturation != '0))
    else $error("hue without saturation");

endmodule

bind rgb_to_hsl_converter_top rhsl_checker #(.FRACTION_BITS(FRACTION_BITS)) u_rhsl_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .red        (red),
  .green      (green),
  .blue       (blue),
  .done       (done),
  .hue        (hue),
  .saturation (saturation),
  .lightness  (lightness)
);
